// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// CBT_ASSERT_RST: property checked only while reset is released.
// CBT_ASSERT_ALWAYS: property checked at every edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CBT_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

`define CBT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

// File: hdl/cbt_pkg.sv
// ---------------------------------------------------------------------------
// cbt_pkg
// Types, constants and helpers for the tone-based color balance pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CH_W      = 13;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int OFS_W     = 14;
    localparam int NUM_CH    = 3;
    localparam int CFG_W     = OFS_W * NUM_CH;
    localparam int CFG_IDX_W = 2;

    // luminance coefficients, 16-bit fractions
    localparam int COEF_W     = 16;
    localparam int LUMA_SHIFT = 16;
    localparam logic [COEF_W-1:0] LUMA_R = 16'd19595;
    localparam logic [COEF_W-1:0] LUMA_G = 16'd38470;
    localparam logic [COEF_W-1:0] LUMA_B = 16'd7471;

    localparam int LPROD_W = CH_W + COEF_W;
    localparam int LSUM_W  = LPROD_W + 1;
    localparam int LUM_W   = LSUM_W - LUMA_SHIFT;

    // offset times weight, offset sum and shifted delta
    localparam int TPROD_W = OFS_W + WGT_W + 1;
    localparam int TSUM_W  = TPROD_W + 2;
    localparam int DELTA_W = TSUM_W - FRAC_BITS;
    localparam int RES_W   = DELTA_W + 1;

    localparam logic [WGT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIDTONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT = 2'd2;

    typedef logic [CH_W-1:0] chan_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } pix_t;

    typedef struct packed {
        logic [CFG_W-1:0] shadow;
        logic [CFG_W-1:0] midtone;
        logic [CFG_W-1:0] highlight;
    } tone_cfg_t;

    typedef struct packed {
        pix_t             pix;
        logic [WGT_W-1:0] sw;
        logic [WGT_W-1:0] mw;
        logic [WGT_W-1:0] hw;
    } wgt_item_t;

    typedef struct packed {
        pix_t                     pix;
        tprod_t [NUM_CH-1:0]      s_prod;
        tprod_t [NUM_CH-1:0]      m_prod;
        tprod_t [NUM_CH-1:0]      h_prod;
    } prod_item_t;

    // signed offset k (0 red, 1 green, 2 blue) of a packed register
    function automatic logic signed [OFS_W-1:0] offset_of(
        input logic [CFG_W-1:0] r,
        input int               k
    );
        return $signed(r[k*OFS_W +: OFS_W]);
    endfunction

    // channel value as seen by the pipeline, in 0/1/2 order
    function automatic chan_t chan_of(input pix_t p, input int k);
        chan_t c;
        case (k)
            0:       c = p.red;
            1:       c = p.green;
            default: c = p.blue;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/color_balance_by_tone.sv
// ---------------------------------------------------------------------------
// color_balance_by_tone
// Shifts R, G and B by shadow/midtone/highlight offsets weighted by luminance.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_red_in, s_green_in, s_blue_in, s_alpha_in
//  m_        out        m_valid/m_ready    m_red_out, m_green_out, m_blue_out, m_alpha_out
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
//  One item per cycle when the output is not stalled; five register stages
//  (luma products, weights, tone products, offset sum, clamp).
//  Each stage holds its item while the one below is full, so bubbles fill
//  up under a stall and s_ready only drops when every stage holds an item.
//  Reset clears the stage valid bits and the three offset registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_balance_by_tone import cbt_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CH_W-1:0]      s_red_in,
    input  wire logic [CH_W-1:0]      s_green_in,
    input  wire logic [CH_W-1:0]      s_blue_in,
    input  wire logic [CH_W-1:0]      s_alpha_in,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CH_W-1:0]           m_red_out,
    output logic [CH_W-1:0]           m_green_out,
    output logic [CH_W-1:0]           m_blue_out,
    output logic [CH_W-1:0]           m_alpha_out,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    tone_cfg_t  cfg_reg;

    pix_t       in_pix;
    logic       wgt_valid;
    logic       wgt_ready;
    wgt_item_t  wgt_item;
    logic       prod_valid;
    logic       prod_ready;
    prod_item_t prod_item;
    pix_t       out_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHADOW:    cfg_reg.shadow    <= cfg_wdata;
                REG_MIDTONE:   cfg_reg.midtone   <= cfg_wdata;
                REG_HIGHLIGHT: cfg_reg.highlight <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    assign in_pix.red   = s_red_in;
    assign in_pix.green = s_green_in;
    assign in_pix.blue  = s_blue_in;
    assign in_pix.alpha = s_alpha_in;

    cbt_luma u_luma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_pix   (in_pix),
        .dn_valid (wgt_valid),
        .dn_ready (wgt_ready),
        .dn_item  (wgt_item)
    );

    cbt_tone_mult u_tone_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .up_valid (wgt_valid),
        .up_ready (wgt_ready),
        .up_item  (wgt_item),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_item  (prod_item)
    );

    cbt_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_item  (prod_item),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_pix   (out_pix)
    );

    assign m_red_out   = out_pix.red;
    assign m_green_out = out_pix.green;
    assign m_blue_out  = out_pix.blue;
    assign m_alpha_out = out_pix.alpha;

endmodule

`default_nettype wire

// File: hdl/cbt_luma.sv
// ---------------------------------------------------------------------------
// cbt_luma
// Two stages: luminance products, then sum and tone weights.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbt_luma import cbt_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire pix_t      up_pix,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output wgt_item_t      dn_item
);

    logic               v1_reg;
    pix_t               pix1_reg;
    logic [LPROD_W-1:0] pr_reg;
    logic [LPROD_W-1:0] pg_reg;
    logic [LPROD_W-1:0] pb_reg;

    logic               v2_reg;
    wgt_item_t          item2_reg;

    logic               en1;
    logic               en2;

    logic [LSUM_W-1:0]  sum;
    logic [LUM_W-1:0]   lum;
    logic [LUM_W:0]     lum2;
    logic [LUM_W:0]     one_x;
    logic [LUM_W:0]     two_one_x;
    wgt_item_t          item2_next;

    assign en2      = !v2_reg || dn_ready;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= up_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && up_valid) begin
            pix1_reg <= up_pix;
            pr_reg   <= LPROD_W'(up_pix.red)   * LPROD_W'(LUMA_R);
            pg_reg   <= LPROD_W'(up_pix.green) * LPROD_W'(LUMA_G);
            pb_reg   <= LPROD_W'(up_pix.blue)  * LPROD_W'(LUMA_B);
        end
        if (en2 && v1_reg) begin
            item2_reg <= item2_next;
        end
    end

    always_comb begin
        sum       = LSUM_W'(pr_reg) + LSUM_W'(pg_reg) + LSUM_W'(pb_reg);
        lum       = sum[LSUM_W-1:LUMA_SHIFT];
        lum2      = {lum, 1'b0};
        one_x     = (LUM_W+1)'(ONE);
        two_one_x = {one_x[LUM_W-1:0], 1'b0};

        item2_next.pix = pix1_reg;
        if (lum2 >= one_x) begin
            item2_next.sw = '0;
        end else begin
            item2_next.sw = WGT_W'(one_x - lum2);
        end
        if (lum2 <= one_x) begin
            item2_next.hw = '0;
        end else if (lum2 >= two_one_x) begin
            item2_next.hw = ONE;
        end else begin
            item2_next.hw = WGT_W'(lum2 - one_x);
        end
        item2_next.mw = ONE - item2_next.sw - item2_next.hw;
    end

    assign dn_valid = v2_reg;
    assign dn_item  = item2_reg;

endmodule

`default_nettype wire

// File: hdl/cbt_tone_mult.sv
// ---------------------------------------------------------------------------
// cbt_tone_mult
// One stage: nine offset-by-weight products, three tones per channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbt_tone_mult import cbt_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tone_cfg_t  cfg,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire wgt_item_t  up_item,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output prod_item_t      dn_item
);

    logic       v_reg;
    prod_item_t item_reg;
    prod_item_t item_next;
    logic       en;

    assign en       = !v_reg || dn_ready;
    assign up_ready = en;

    always_comb begin
        item_next.pix = up_item.pix;
        for (int k = 0; k < NUM_CH; k++) begin
            item_next.s_prod[k] = TPROD_W'(offset_of(cfg.shadow, k))
                                * TPROD_W'($signed({1'b0, up_item.sw}));
            item_next.m_prod[k] = TPROD_W'(offset_of(cfg.midtone, k))
                                * TPROD_W'($signed({1'b0, up_item.mw}));
            item_next.h_prod[k] = TPROD_W'(offset_of(cfg.highlight, k))
                                * TPROD_W'($signed({1'b0, up_item.hw}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && up_valid) begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = v_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// File: hdl/cbt_mix.sv
// ---------------------------------------------------------------------------
// cbt_mix
// Two stages: offset sum with floor shift, then channel add and clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbt_mix import cbt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire prod_item_t  up_item,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output pix_t             dn_pix
);

    logic                      va_reg;
    pix_t                      pixa_reg;
    delta_t [NUM_CH-1:0]       delta_reg;
    delta_t [NUM_CH-1:0]       delta_next;

    logic                      vb_reg;
    pix_t                      pixb_reg;
    chan_t  [NUM_CH-1:0]       res_next;

    logic                      ena;
    logic                      enb;

    logic signed [TSUM_W-1:0]  tsum;
    logic signed [RES_W-1:0]   val;

    assign enb      = !vb_reg || dn_ready;
    assign ena      = !va_reg || enb;
    assign up_ready = ena;

    // dropping the low bits of a two's complement sum is a floor shift
    always_comb begin
        tsum = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            tsum = TSUM_W'(up_item.s_prod[k]) + TSUM_W'(up_item.m_prod[k])
                 + TSUM_W'(up_item.h_prod[k]);
            delta_next[k] = tsum[TSUM_W-1:FRAC_BITS];
        end
    end

    always_comb begin
        val = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            val = $signed({{(RES_W-CH_W){1'b0}}, chan_of(pixa_reg, k)})
                + RES_W'(delta_reg[k]);
            if (val < 0) begin
                res_next[k] = '0;
            end else if (val > $signed(RES_W'(ONE))) begin
                res_next[k] = CH_W'(ONE);
            end else begin
                res_next[k] = val[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ena) begin
                va_reg <= up_valid;
            end
            if (enb) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ena && up_valid) begin
            pixa_reg  <= up_item.pix;
            delta_reg <= delta_next;
        end
        if (enb && va_reg) begin
            pixb_reg.red   <= res_next[0];
            pixb_reg.green <= res_next[1];
            pixb_reg.blue  <= res_next[2];
            pixb_reg.alpha <= pixa_reg.alpha;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_pix   = pixb_reg;

endmodule

`default_nettype wire

// File: hdl/cbt_checker.sv
// ---------------------------------------------------------------------------
// cbt_checker
// Port-level checks on the color balance block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbt_checker import cbt_pkg::*; (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [CH_W-1:0] m_red_out,
    input wire logic [CH_W-1:0] m_green_out,
    input wire logic [CH_W-1:0] m_blue_out,
    input wire logic [CH_W-1:0] m_alpha_out
);

    // pipeline comes out of reset empty
    `CBT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // adjusted colors are always clamped to one
    `CBT_ASSERT_RST(a_color_range, aclk, aresetn,
        m_valid |-> (m_red_out <= CH_W'(ONE)) && (m_green_out <= CH_W'(ONE))
            && (m_blue_out <= CH_W'(ONE)))

    // input can only be blocked when a result is waiting at the output
    `CBT_ASSERT_RST(a_ready_only_full, aclk, aresetn, !s_ready |-> m_valid)

    // a drained output never blocks the input
    `CBT_ASSERT_RST(a_ready_when_drained, aclk, aresetn, m_ready |-> s_ready)

    // a stalled result holds
    `CBT_ASSERT_RST(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_alpha_out))

endmodule

bind color_balance_by_tone cbt_checker u_cbt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red_out   (m_red_out),
    .m_green_out (m_green_out),
    .m_blue_out  (m_blue_out),
    .m_alpha_out (m_alpha_out)
);

`default_nettype wire

// File: tb/tb_color_balance_by_tone.sv
// ---------------------------------------------------------------------------
// tb_color_balance_by_tone
// Self-checking bench for the tone-based color balance pipeline. Pixels go in
// over s_valid/s_ready; a local model predicts each adjusted pixel from its
// own copy of the three offset registers, and every result taken from
// m_valid/m_ready is compared field by field, in order. Directed pixels and
// offset extremes come first, then random offsets and pixels with random
// stalls on one or both sides, and a final stretch at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_color_balance_by_tone;
    import cbt_pkg::*;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    DRAIN_CYCLES   = 8;
    localparam int    RANDOM_PHASES  = 7;
    localparam int    PHASE_ITEMS    = 170;
    localparam int    FULL_RATE_ITEMS = 110;
    localparam longint ONE_L   = longint'(1) << FRAC_BITS;
    localparam longint COEF_R  = 19595;
    localparam longint COEF_G  = 38470;
    localparam longint COEF_B  = 7471;
    localparam int    MAX_OFS  = 8191;
    localparam int    MIN_OFS  = -8192;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    chan_t                s_red_in = '0;
    chan_t                s_green_in = '0;
    chan_t                s_blue_in = '0;
    chan_t                s_alpha_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    chan_t                m_red_out;
    chan_t                m_green_out;
    chan_t                m_blue_out;
    chan_t                m_alpha_out;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // local copy of the offset registers
    logic [CFG_W-1:0] ofs_shadow = '0;
    logic [CFG_W-1:0] ofs_midtone = '0;
    logic [CFG_W-1:0] ofs_highlight = '0;

    pix_t pending_pixels [$];
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   src_idle_pct = 0;
    int   sink_idle_pct = 0;

    color_balance_by_tone uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint tone_offset(input logic [CFG_W-1:0] word, input int k);
        logic signed [OFS_W-1:0] raw;
        raw = word[k*OFS_W +: OFS_W];
        return longint'(raw);
    endfunction

    function automatic logic [CFG_W-1:0] pack_offsets(input int r, input int g, input int b);
        logic [OFS_W-1:0] rr;
        logic [OFS_W-1:0] gg;
        logic [OFS_W-1:0] bb;
        rr = r[OFS_W-1:0];
        gg = g[OFS_W-1:0];
        bb = b[OFS_W-1:0];
        return {bb, gg, rr};
    endfunction

    // expected output pixel under the current offset copy
    function automatic pix_t balance_pixel(input pix_t p);
        pix_t   res;
        longint c [3];
        longint lum;
        longint w_sh;
        longint w_hi;
        longint w_mid;
        longint acc;
        chan_t  adj [3];
        c[0] = p.red;
        c[1] = p.green;
        c[2] = p.blue;
        lum   = (COEF_R * c[0] + COEF_G * c[1] + COEF_B * c[2]) >> 16;
        w_sh  = clamp_to(ONE_L - 2 * lum, 0, ONE_L);
        w_hi  = clamp_to(2 * lum - ONE_L, 0, ONE_L);
        w_mid = ONE_L - w_sh - w_hi;
        for (int k = 0; k < 3; k++) begin
            acc = tone_offset(ofs_shadow, k) * w_sh
                + tone_offset(ofs_midtone, k) * w_mid
                + tone_offset(ofs_highlight, k) * w_hi;
            // >>> on a signed longint floors toward minus infinity
            adj[k] = chan_t'(clamp_to(c[k] + (acc >>> FRAC_BITS), 0, ONE_L));
        end
        res.red   = adj[0];
        res.green = adj[1];
        res.blue  = adj[2];
        res.alpha = p.alpha;
        return res;
    endfunction

    task automatic check_field(input string name, input chan_t want, input chan_t got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // predictor and scoreboard, all on pre-edge values
    always @(posedge aclk) begin : monitor
        pix_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SHADOW:    ofs_shadow = cfg_wdata;
                    REG_MIDTONE:   ofs_midtone = cfg_wdata;
                    REG_HIGHLIGHT: ofs_highlight = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_pixels.push_back(balance_pixel('{s_red_in, s_green_in, s_blue_in,
                                                         s_alpha_in}));
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0d %0d %0d %0d",
                             $time, m_red_out, m_green_out, m_blue_out, m_alpha_out);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("red_out", want.red, m_red_out);
                    check_field("green_out", want.green, m_green_out);
                    check_field("blue_out", want.blue, m_blue_out);
                    check_field("alpha_out", want.alpha, m_alpha_out);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("color_balance_by_tone: mismatch");
            $finish;
        end
    end

    // result-side backpressure
    always begin
        @(posedge aclk);
        if (aresetn && sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
            m_ready <= 1'b1;
        end
    end

    task automatic send_pixel(input pix_t p);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= p.red;
        s_green_in <= p.green;
        s_blue_in  <= p.blue;
        s_alpha_in <= p.alpha;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // registers only change with the pipeline empty
    task automatic write_offsets(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic chan_t rand_chan();
        case ($urandom_range(0, 9))
            0:       return chan_t'($urandom);            // full field, above ONE too
            1:       return ($urandom_range(0, 1)) ? chan_t'(ONE) : '0;
            default: return chan_t'($urandom_range(0, ONE));
        endcase
    endfunction

    function automatic pix_t rand_pixel();
        pix_t p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        p.alpha = rand_chan();
        return p;
    endfunction

    function automatic int rand_offset();
        case ($urandom_range(0, 3))
            0:       return MAX_OFS;
            1:       return MIN_OFS;
            2:       return $urandom_range(0, 1) ? -1 : 0;
            default: return int'($urandom_range(0, 16383)) - 8192;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_offsets();
        case ($urandom_range(0, 3))
            0:       return CFG_W'({$urandom, $urandom});
            1:       return pack_offsets(int'($urandom_range(0, 1024)) - 512,
                                         int'($urandom_range(0, 1024)) - 512,
                                         int'($urandom_range(0, 1024)) - 512);
            2:       return pack_offsets(rand_offset(), rand_offset(), rand_offset());
            default: return pack_offsets(int'($urandom_range(0, 8192)) - 4096,
                                         int'($urandom_range(0, 8192)) - 4096,
                                         int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic pix_t tone_pixel(input int i);
        case (i)
            0:       return '{13'd0, 13'd0, 13'd0, 13'd0};
            1:       return '{13'd4096, 13'd4096, 13'd4096, 13'd4096};
            2:       return '{13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff};
            3:       return '{13'd2048, 13'd2048, 13'd2048, 13'd1};   // pure midtone
            4:       return '{13'd4096, 13'd0, 13'd0, 13'h1555};
            5:       return '{13'd0, 13'd4096, 13'd0, 13'h0aaa};
            6:       return '{13'd0, 13'd0, 13'd4096, 13'd4095};
            default: return '{13'd1024, 13'd1031, 13'd1017, 13'd0};  // shadow/midtone mix
        endcase
    endfunction

    task automatic send_tone_pixels();
        for (int i = 0; i < 8; i++) send_pixel(tone_pixel(i));
    endtask

    // zero offsets after reset: color passes through, out-of-range clamps
    task automatic test_reset_values();
        send_tone_pixels();
    endtask

    task automatic test_offset_extremes();
        write_offsets(REG_SHADOW, pack_offsets(MAX_OFS, MIN_OFS, -1));
        write_offsets(REG_MIDTONE, pack_offsets(MIN_OFS, MAX_OFS, 1));
        write_offsets(REG_HIGHLIGHT, pack_offsets(-1, MIN_OFS, MAX_OFS));
        send_tone_pixels();
        write_offsets(REG_SHADOW, pack_offsets(MIN_OFS, MIN_OFS, MIN_OFS));
        write_offsets(REG_MIDTONE, pack_offsets(-3, -4095, -1));
        write_offsets(REG_HIGHLIGHT, pack_offsets(MAX_OFS, MAX_OFS, MAX_OFS));
        send_tone_pixels();
    endtask

    // index 3 maps to no register
    task automatic test_unused_index();
        write_offsets(REG_UNUSED, '1);
        send_pixel(tone_pixel(3));
        send_pixel(tone_pixel(7));
    endtask

    task automatic test_random_balance();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_offsets(REG_SHADOW, rand_offsets());
            write_offsets(REG_MIDTONE, rand_offsets());
            write_offsets(REG_HIGHLIGHT, rand_offsets());
            src_idle_pct  = (ph % 3 == 2) ? 0 : $urandom_range(0, 40);
            sink_idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(0, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(rand_pixel());
        end
    endtask

    task automatic test_full_rate();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_offsets(REG_SHADOW, rand_offsets());
        write_offsets(REG_MIDTONE, rand_offsets());
        write_offsets(REG_HIGHLIGHT, rand_offsets());
        for (int n = 0; n < FULL_RATE_ITEMS; n++) send_pixel(rand_pixel());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_offset_extremes();
        test_unused_index();
        test_random_balance();
        test_full_rate();
        drain_pipeline();
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d items expected, none arrived", $time, pending_pixels.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("color_balance_by_tone: match");
        else
            $display("color_balance_by_tone: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/cbt_pkg.sv
hdl/cbt_luma.sv
hdl/cbt_tone_mult.sv
hdl/cbt_mix.sv
hdl/color_balance_by_tone.sv
hdl/cbt_checker.sv
tb/tb_color_balance_by_tone.sv
